@@ hw/rtl/fcd_pkg.sv @@
`default_nettype none

package fcd_pkg;

	// Frame store geometry.
	localparam int MAX_PIXELS = 65536;
	localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LEN_W = POS_W + 1;

	// Field and register widths.
	localparam int PIX_W = 24;
	localparam int CH_W = 8;
	localparam int COUNT_W = 17;
	localparam int FRAME_W = 16;
	localparam int THR_W = 16;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 1;

	// Register reset values.
	localparam logic [CFG_W-1:0] PIXELS_RESET = 17'd65536;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd13107;

	// Grey conversion weights, fixed point with 14 fraction bits.
	localparam int WSUM_W = 22;
	localparam logic [WSUM_W-1:0] GREY_W_B = 22'd1868;
	localparam logic [WSUM_W-1:0] GREY_W_G = 22'd9617;
	localparam logic [WSUM_W-1:0] GREY_W_R = 22'd4899;
	localparam logic [WSUM_W-1:0] GREY_ROUND = 22'd8192;
	localparam int GREY_SHIFT = 14;

	// Changed count is scaled by 65536 before the threshold compare.
	localparam int COUNT_SCALE_SHIFT = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam int PROD_W = THR_W + LEN_W;
	localparam int SCALED_W = COUNT_W + COUNT_SCALE_SHIFT;
	localparam int CMP_W = (PROD_W > SCALED_W) ? PROD_W : SCALED_W;

	// Result queue sizing: the pipeline can hold this many pending results.
	localparam int PIPE_RESULTS = 4;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_PIXELS = 1'b0,
		REG_CHANGE_THRESHOLD = 1'b1
	} cfg_reg_t;

	// One finished-frame result.
	typedef struct packed {
		logic keep_frame;
		logic [COUNT_W-1:0] changed_pixels;
		logic [FRAME_W-1:0] frame_number;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcd_ram.sv @@
`default_nettype none

module fcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Simple dual port; a read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fcd_result_fifo.sv @@
`default_nettype none

module fcd_result_fifo
	import fcd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire result_t push_data,
	input wire logic pop,
	output logic head_valid,
	output result_t head_data,
	output logic [FIFO_CNT_W-1:0] fill
);

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fill_q;
	logic do_pop;

	assign head_valid = (fill_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign fill = fill_q;
	assign do_pop = pop && head_valid;

	// Pointers and fill level. The writer never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10: fill_q <= fill_q + FIFO_CNT_W'(1);
				2'b01: fill_q <= fill_q - FIFO_CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/frame_change_detector.sv @@
`default_nettype none

// Channel   Ports                                                Handshake
// pixel     pixel[23:0]                                          pixel_valid / pixel_stall
// result    keep_frame, changed_pixels[16:0], frame_number[15:0] result_valid / result_stall
// config    cfg_index[0:0], cfg_data[16:0]                       cfg_write
//
// One pixel item is taken every cycle while pixel_stall is low. Each pixel reads both
// banks of the frame store at accept and is written back to the spare bank from stage 3,
// once the bank choice of the previous frame is settled. Frames of one to three pixels
// pause input until that write-back lands. The result of a frame passes from its last
// pixel through the pipeline stages into an eight-entry queue and is offered from there;
// input pauses while four or more results are waiting. Reset clears the control state
// and loads the register reset values; the frame store is not cleared.
module frame_change_detector
	import fcd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic pixel_valid,
	output logic pixel_stall,
	input wire logic [PIX_W-1:0] pixel,
	output logic result_valid,
	input wire logic result_stall,
	output logic keep_frame,
	output logic [COUNT_W-1:0] changed_pixels,
	output logic [FRAME_W-1:0] frame_number
);

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Nonzero grey value of the per-channel differences.
	function automatic logic grey_nonzero(input logic [CH_W-1:0] db,
			input logic [CH_W-1:0] dg, input logic [CH_W-1:0] dr);
		logic [WSUM_W-1:0] wsum;
		wsum = WSUM_W'(db) * GREY_W_B + WSUM_W'(dg) * GREY_W_G
			+ WSUM_W'(dr) * GREY_W_R + GREY_ROUND;
		return (wsum >> GREY_SHIFT) != '0;
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0] frame_pixels_q;
	logic [THR_W-1:0] threshold_q;
	logic [PROD_W-1:0] limit_q;

	// Control state.
	logic [POS_W-1:0] pos_q;
	logic [COUNT_W-1:0] count_q;
	logic [FRAME_W-1:0] frame_q;
	logic refsel_q;
	logic have_ref_q;

	// Pipeline stages.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic last_s1, last_s2, last_s3;
	logic [POS_W-1:0] pos_s1, pos_s2, pos_s3;
	logic [PIX_W-1:0] pix_s1, pix_s2, pix_s3;
	logic [CH_W-1:0] db0_s2, dg0_s2, dr0_s2, db1_s2, dg1_s2, dr1_s2;
	logic chg0_s3, chg1_s3;
	logic first_s4;
	logic [COUNT_W-1:0] cnt_s4;
	logic [FRAME_W-1:0] frame_s4;

	logic [LEN_W-1:0] len;
	logic [31:0] fp_ext;
	logic last_now;
	logic accept;
	logic hazard;
	logic [PIX_W-1:0] rd0, rd1;
	logic keep_s4;
	logic refsel_eff;
	logic have_ref_eff;
	logic inc_s3;
	logic [COUNT_W-1:0] count_next;
	result_t push_data;
	result_t head_data;
	logic [FIFO_CNT_W-1:0] fifo_fill;

	// Effective frame length: zero acts as one, the store size caps it.
	always_comb begin
		fp_ext = 32'(frame_pixels_q);
		if (fp_ext == 32'd0) begin
			len = LEN_W'(1);
		end else if (fp_ext > 32'(MAX_PIXELS)) begin
			len = LEN_W'(MAX_PIXELS);
		end else begin
			len = LEN_W'(fp_ext);
		end
	end

	assign last_now = ({1'b0, pos_q} + LEN_W'(1)) >= len;

	// Interlock: a pending write-back to the position about to be read.
	assign hazard = (valid_s1 && (pos_s1 == pos_q)) || (valid_s2 && (pos_s2 == pos_q))
		|| (valid_s3 && (pos_s3 == pos_q));

	assign pixel_stall = hazard || (fifo_fill > FIFO_CNT_W'(FIFO_DEPTH - PIPE_RESULTS - 1));
	assign accept = pixel_valid && !pixel_stall;

	// Configuration writes and the threshold limit product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= PIXELS_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_PIXELS: frame_pixels_q <= cfg_data;
				REG_CHANGE_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		limit_q <= PROD_W'(threshold_q) * PROD_W'(len);
	end

	// Frame store: one bank per memory, both read for every pixel.
	fcd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_PIXELS),
		.ADDR_W(POS_W)
	) u_bank0 (
		.clk(clk),
		.wr_en(valid_s3 && refsel_eff),
		.wr_addr(pos_s3),
		.wr_data(pix_s3),
		.rd_en(accept),
		.rd_addr(pos_q),
		.rd_data(rd0)
	);

	fcd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_PIXELS),
		.ADDR_W(POS_W)
	) u_bank1 (
		.clk(clk),
		.wr_en(valid_s3 && !refsel_eff),
		.wr_addr(pos_s3),
		.wr_data(pix_s3),
		.rd_en(accept),
		.rd_addr(pos_q),
		.rd_data(rd1)
	);

	// Keep decision of the frame in stage 4, forwarded to stage 3.
	assign keep_s4 = first_s4
		|| (CMP_W'({cnt_s4, {COUNT_SCALE_SHIFT{1'b0}}}) > CMP_W'(limit_q));
	assign refsel_eff = (valid_s4 && keep_s4) ? !refsel_q : refsel_q;
	assign have_ref_eff = have_ref_q || (valid_s4 && keep_s4);

	// Changed-pixel count with saturation.
	assign inc_s3 = have_ref_eff && (refsel_eff ? chg1_s3 : chg0_s3);
	assign count_next = (inc_s3 && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1)
		: count_q;

	// Control registers and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			count_q <= '0;
			frame_q <= '0;
			refsel_q <= 1'b0;
			have_ref_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && last_s3;
			if (accept) begin
				pos_q <= last_now ? '0 : pos_q + POS_W'(1);
			end
			if (valid_s3) begin
				if (last_s3) begin
					count_q <= '0;
					frame_q <= frame_q + FRAME_W'(1);
				end else begin
					count_q <= count_next;
				end
			end
			if (valid_s4 && keep_s4) begin
				refsel_q <= !refsel_q;
				have_ref_q <= 1'b1;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
		pos_s1 <= pos_q;
		last_s1 <= last_now;

		pix_s2 <= pix_s1;
		pos_s2 <= pos_s1;
		last_s2 <= last_s1;
		db0_s2 <= abs_diff(pix_s1[7:0], rd0[7:0]);
		dg0_s2 <= abs_diff(pix_s1[15:8], rd0[15:8]);
		dr0_s2 <= abs_diff(pix_s1[23:16], rd0[23:16]);
		db1_s2 <= abs_diff(pix_s1[7:0], rd1[7:0]);
		dg1_s2 <= abs_diff(pix_s1[15:8], rd1[15:8]);
		dr1_s2 <= abs_diff(pix_s1[23:16], rd1[23:16]);

		pix_s3 <= pix_s2;
		pos_s3 <= pos_s2;
		last_s3 <= last_s2;
		chg0_s3 <= grey_nonzero(db0_s2, dg0_s2, dr0_s2);
		chg1_s3 <= grey_nonzero(db1_s2, dg1_s2, dr1_s2);

		first_s4 <= !have_ref_eff;
		cnt_s4 <= count_next;
		frame_s4 <= frame_q;
	end

	// Result queue.
	always_comb begin
		push_data.keep_frame = keep_s4;
		push_data.changed_pixels = cnt_s4;
		push_data.frame_number = frame_s4;
	end

	fcd_result_fifo u_result_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s4),
		.push_data(push_data),
		.pop(!result_stall),
		.head_valid(result_valid),
		.head_data(head_data),
		.fill(fifo_fill)
	);

	assign keep_frame = head_data.keep_frame;
	assign changed_pixels = head_data.changed_pixels;
	assign frame_number = head_data.frame_number;

endmodule

`default_nettype wire
